>>> src/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Segmented stack package
// Shared constants, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CAP_W       = 9;
    localparam int IDX_W       = 8;
    localparam int DATA_W      = 64;
    localparam int STK_W       = 9;
    localparam int PROD_W      = IDX_W + CAP_W + 1;
    localparam int DIV_W       = $clog2(STORE_DEPTH + (1 << CAP_W));
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_POP_AT = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_STACK = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_EXEC,
        S_READ,
        S_SHIFT,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic exec;
        logic read_lat;
        logic shift_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_read;
        logic is_pop_at;
        logic shift_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

>>> src/ssp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ssp_dpath.sv
// ----------------------------------------------------------------------------
// Segmented stack datapath
// Value store, item count, stack bounds, shift engine and stack count divider.
// ----------------------------------------------------------------------------
module ssp_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [ssp_pkg::CAP_W-1:0]  i_cfg_data,
    input  ssp_pkg::t_mode             i_in_mode,
    input  logic [ssp_pkg::DATA_W-1:0] i_in_value,
    input  logic [ssp_pkg::IDX_W-1:0]  i_in_idx,
    input  ssp_pkg::t_cmd              i_cmd,
    output ssp_pkg::t_stat             o_stat,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [ssp_pkg::DATA_W-1:0] o_out_popped,
    output logic [1:0]                 o_out_status,
    output logic [ssp_pkg::STK_W-1:0]  o_out_stacks,
    output logic                       o_out_empty
);

    import ssp_pkg::*;

    logic [CAP_W-1:0]     r_cap;
    logic [CNT_W-1:0]     r_count;
    logic                 r_wr_pend;
    logic                 r_out_valid;
    t_mode                r_mode;
    logic [DATA_W-1:0]    r_value;
    logic [IDX_W-1:0]     r_idx;
    logic [PROD_W-1:0]    r_prod;
    logic [ADDR_W-1:0]    r_pos;
    logic [DATA_W-1:0]    r_popped;
    t_status              r_status;
    logic [CNT_W-1:0]     r_ptr;
    logic [ADDR_W-1:0]    r_wr_addr;
    logic [DIV_W-1:0]     r_div_num;
    logic [CAP_W-1:0]     r_div_rem;
    logic [DIV_W-1:0]     r_div_q;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DATA_W-1:0]    r_out_popped;
    t_status              r_out_status;
    logic [STK_W-1:0]     r_out_stacks;
    logic                 r_out_empty;

    logic [CAP_W-1:0]  cap_eff;
    logic [PROD_W-1:0] count_ext;
    logic [PROD_W-1:0] end_full;
    logic [PROD_W-1:0] end_clip;
    logic [PROD_W-1:0] pos_ext;
    logic [ADDR_W-1:0] pos;
    logic              no_items;
    logic              is_full;
    logic              stack_ok;
    logic              need_read;
    logic              shift_more;
    logic              shift_done;
    logic [CAP_W:0]    div_trial;
    logic [CAP_W:0]    div_diff;
    logic              div_ge;
    logic [CAP_W-1:0]  n_div_rem;
    logic              div_done;
    logic              out_free;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    always_comb begin
        cap_eff    = (r_cap == '0) ? CAP_W'(1) : r_cap;
        count_ext  = PROD_W'(r_count);
        end_full   = r_prod + PROD_W'(cap_eff);
        end_clip   = (end_full > count_ext) ? count_ext : end_full;
        pos_ext    = end_clip - PROD_W'(1);
        pos        = pos_ext[ADDR_W-1:0];
        no_items   = (r_count == '0);
        is_full    = (r_count == CNT_W'(STORE_DEPTH));
        stack_ok   = (r_prod < count_ext);
        need_read  = !no_items && ((r_mode == MODE_POP) ||
                                   ((r_mode == MODE_POP_AT) && stack_ok));
        shift_more = (r_ptr < r_count);
        shift_done = !r_wr_pend && !shift_more;
        div_trial  = {r_div_rem, r_div_num[DIV_W-1]};
        div_diff   = div_trial - {1'b0, cap_eff};
        div_ge     = (div_trial >= {1'b0, cap_eff});
        n_div_rem  = div_ge ? div_diff[CAP_W-1:0] : div_trial[CAP_W-1:0];
        div_done   = (r_div_cnt == DIV_CNT_W'(DIV_W - 1));
        out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[ADDR_W-1:0];
        ram_wdata = r_value;
        ram_raddr = pos;
        if (i_cmd.exec) begin
            ram_we = (r_mode == MODE_PUSH) && !is_full;
            if (r_mode == MODE_POP) begin
                ram_raddr = ADDR_W'(r_count - CNT_W'(1));
            end
        end
        if (i_cmd.shift_step) begin
            ram_raddr = r_ptr[ADDR_W-1:0];
            if (r_wr_pend) begin
                ram_we    = 1'b1;
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
            end
        end
    end

    ssp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                case (r_mode)
                    MODE_PUSH: begin
                        if (!is_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    MODE_POP: begin
                        if (!no_items) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.read_lat) begin
                r_wr_pend <= 1'b0;
            end
            if (i_cmd.shift_step) begin
                r_wr_pend <= shift_more;
                if (shift_done) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode   <= i_in_mode;
            r_value  <= i_in_value;
            r_idx    <= i_in_idx;
            r_popped <= '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_idx) * PROD_W'(cap_eff);
        end
        if (i_cmd.exec) begin
            r_pos <= pos;
            case (r_mode)
                MODE_PUSH:   r_status <= is_full ? ST_FULL : ST_OK;
                MODE_POP:    r_status <= no_items ? ST_EMPTY : ST_OK;
                MODE_POP_AT: begin
                    if (no_items) begin
                        r_status <= ST_EMPTY;
                    end else if (!stack_ok) begin
                        r_status <= ST_NO_STACK;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                default:     r_status <= ST_OK;
            endcase
        end
        if (i_cmd.read_lat) begin
            r_popped <= ram_rdata;
            r_ptr    <= CNT_W'(r_pos) + CNT_W'(1);
        end
        if (i_cmd.shift_step && shift_more) begin
            r_ptr     <= r_ptr + CNT_W'(1);
            r_wr_addr <= ADDR_W'(r_ptr - CNT_W'(1));
        end
        if (i_cmd.div_start) begin
            r_div_num <= DIV_W'(r_count) + DIV_W'(cap_eff) - DIV_W'(1);
            r_div_rem <= '0;
            r_div_q   <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[DIV_W-2:0], 1'b0};
            r_div_rem <= n_div_rem;
            r_div_q   <= {r_div_q[DIV_W-2:0], div_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_popped <= r_popped;
            r_out_status <= r_status;
            r_out_stacks <= STK_W'(r_div_q);
            r_out_empty  <= no_items;
        end
    end

    assign o_stat.need_read  = need_read;
    assign o_stat.is_pop_at  = (r_mode == MODE_POP_AT);
    assign o_stat.shift_done = shift_done;
    assign o_stat.div_done   = div_done;
    assign o_stat.out_free   = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_popped = r_out_popped;
    assign o_out_status = r_out_status;
    assign o_out_stacks = r_out_stacks;
    assign o_out_empty  = r_out_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("Item count exceeds the store depth.");

    a_pos_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && need_read && (r_mode == MODE_POP_AT)) |-> (CNT_W'(pos) < r_count))
        else $error("Pop-at position lies outside the used store.");

    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_step && shift_done) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("Item count not reduced after the shift.");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("Result loaded over a beat still waiting.");

endmodule

>>> src/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// Segmented stack controller
// Sequences bound check, store access, shift, stack count and result beat.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ssp_pkg::t_stat i_stat,
    output ssp_pkg::t_cmd  o_cmd
);

    import ssp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL;
            S_MUL:    n_state = S_EXEC;
            S_EXEC:   n_state = i_stat.need_read ? S_READ : S_DSTART;
            S_READ:   n_state = i_stat.is_pop_at ? S_SHIFT : S_DSTART;
            S_SHIFT:  if (i_stat.shift_done) n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (i_stat.div_done) n_state = S_OUT;
            S_OUT:    if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_MUL:    o_cmd.mul        = 1'b1;
            S_EXEC:   o_cmd.exec       = 1'b1;
            S_READ:   o_cmd.read_lat   = 1'b1;
            S_SHIFT:  o_cmd.shift_step = 1'b1;
            S_DSTART: o_cmd.div_start  = 1'b1;
            S_DIV:    o_cmd.div_step   = 1'b1;
            S_OUT:    o_cmd.out_load   = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

>>> src/segmented_stack_pop_at_top.sv
// ----------------------------------------------------------------------------
// Segmented stack with pop-at
// Set of bounded stacks kept in one flat store with push, pop and pop-at.
//
//   Channel   Direction  Handshake             Contents
//   s_axis    in         tvalid / tready       mode, push value, stack index
//   m_axis    out        tvalid / tready       popped value, status, counts
//   cfg       in         valid / ready         stack capacity
//
// Push, pop and the unused mode pass through the product step, the store
// access, a registered store read for pops and a 10-step stack count
// divider before the result beat. Pop-at adds a shift that moves each value
// above the popped position down one place via the store read and write ports.
// Reset clears the item count and restores a capacity of eight.
// A new beat is accepted while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module segmented_stack_pop_at_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // push_value[63:0], stack_index[71:64]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // popped_value[63:0], stacks_in_use[72:64],
                                        // set_empty[73], zero fill[79:74]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    import ssp_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] out_popped;
    logic [1:0]        out_status;
    logic [STK_W-1:0]  out_stacks;
    logic              out_empty;

    ssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_mode    (t_mode'(s_axis_tuser)),
        .i_in_value   (s_axis_tdata[63:0]),
        .i_in_idx     (s_axis_tdata[71:64]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_popped (out_popped),
        .o_out_status (out_status),
        .o_out_stacks (out_stacks),
        .o_out_empty  (out_empty)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {6'b0, out_empty, out_stacks, out_popped};
    assign m_axis_tuser = out_status;

endmodule
